### rtl/i2cms_pkg.sv
`timescale 1ns / 1ps
package i2cms_pkg;

	// Width of the transfer byte counters.
	localparam int COUNT_BITS = 16;
	typedef logic [COUNT_BITS-1:0] cnt_t;

	// Stream widths: fields packed from bit 0 and padded to whole bytes.
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 40;

	// Depth of the queue between the front and the back. Must be a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_START_TX = 2'd0,
		OP_START_RX = 2'd1,
		OP_EVENT    = 2'd2,
		OP_ERROR    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		XS_READY = 2'd0,
		XS_TX    = 2'd1,
		XS_RX    = 2'd2
	} xfer_state_t;

	typedef enum logic [1:0] {
		ACK_KEEP  = 2'd0,
		ACK_CLEAR = 2'd1,
		ACK_SET   = 2'd2
	} ack_t;

	// Notification bit positions.
	localparam int NT_TX_DONE = 0;
	localparam int NT_RX_DONE = 1;
	localparam int NT_STOP    = 2;
	localparam int NT_DATA_RQ = 3;
	localparam int NT_DATA_RX = 4;
	localparam int NT_ERR_LO  = 5;
	localparam int NT_ERR_HI  = 9;

	// Event flags, laid out so that the struct matches the raw bit order.
	typedef struct packed {
		logic rxne;
		logic txe;
		logic stopf;
		logic btf;
		logic addr;
		logic sb;
	} ev_flags_t;

	// One classified request as it waits in the queue.
	typedef struct packed {
		op_t       op;
		logic [6:0] target_addr;
		cnt_t      length;
		logic      hold_bus;
		ev_flags_t ev;
		logic [4:0] error_flags;
		logic      msl;
		logic      tra;
		logic [7:0] tx_byte;
		logic [7:0] rx_byte;
	} item_t;

	// Queue status seen by the front and the back.
	typedef struct packed {
		logic full;
		logic nonempty;
	} q_status_t;

	// One result; the last member lands in the lowest bits of tdata.
	typedef struct packed {
		logic [2:0]  irq_enables;
		logic [9:0]  notify_mask;
		logic        clear_addr;
		ack_t        ack_control;
		logic        stop_request;
		logic        start_request;
		logic [7:0]  rx_data;
		logic        rx_valid;
		logic        tx_consumed;
		logic [7:0]  write_byte;
		logic        write_valid;
		xfer_state_t busy_before;
	} result_t;

endpackage

### rtl/i2c_master_event_sequencer_top.sv
`timescale 1ns / 1ps
// Channel     Direction  Handshake                     Payload
// s_axis      in         s_axis_tvalid / s_axis_tready s_axis_tdata (56), s_axis_tuser (2)
// m_axis      out        m_axis_tvalid / m_axis_tready m_axis_tdata (40)
//
// Every request yields exactly one result. A request passes through the front
// register and the queue before the back executes it into the output register.
// The back executes one request per cycle against its transfer state while m_axis
// is not stalled, giving a sustained rate of one request per clock.
// arst_n clears the transfer state, counters, interrupt enables and all valid flags.
// A stall on m_axis holds the result in the output register; the two-entry queue
// and the front register keep accepting until both are full.
module i2c_master_event_sequencer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata fields from bit 0: target_addr(7), length(16), hold_bus(1),
	// event_flags(6), error_flags(5), mode_flags(2), tx_byte(8), rx_byte(8), zero pad(3).
	input  logic [i2cms_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// tuser fields from bit 0: op(2).
	input  logic [1:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata fields from bit 0: busy_before(2), write_valid(1), write_byte(8),
	// tx_consumed(1), rx_valid(1), rx_data(8), start_request(1), stop_request(1),
	// ack_control(2), clear_addr(1), notify_mask(10), irq_enables(3), zero pad(1).
	output logic [i2cms_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// The front only decodes and classifies; all transfer state lives in the back,
	// so the queue between them may hold requests freely without hazards.
	i2cms_pkg::q_status_t q_status;
	i2cms_pkg::item_t     push_item;
	i2cms_pkg::item_t     head_item;
	logic                 push;
	logic                 pop;

	i2cms_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_status      (q_status),
		.push          (push),
		.push_item     (push_item)
	);

	i2cms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.q_status  (q_status)
	);

	// The back pops a request whenever the queue is nonempty and the output register is
	// empty or being drained in the same cycle, and commits its state change at that edge.
	i2cms_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.head_item     (head_item),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

### rtl/i2cms_front.sv
`timescale 1ns / 1ps
module i2cms_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [i2cms_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  logic [1:0]                           s_axis_tuser,
	input  i2cms_pkg::q_status_t                 q_status,
	output logic                                 push,
	output i2cms_pkg::item_t                     push_item
);

	logic             valid_s1;
	i2cms_pkg::item_t item_s1;
	i2cms_pkg::item_t decoded;

	// Unpack the stream word into named fields.
	always_comb begin
		decoded.op             = i2cms_pkg::op_t'(s_axis_tuser);
		decoded.target_addr    = s_axis_tdata[6:0];
		decoded.length         = i2cms_pkg::cnt_t'(s_axis_tdata[22:7]);
		decoded.hold_bus       = s_axis_tdata[23];
		decoded.ev             = i2cms_pkg::ev_flags_t'(s_axis_tdata[29:24]);
		decoded.error_flags    = s_axis_tdata[34:30];
		decoded.msl            = s_axis_tdata[35];
		decoded.tra            = s_axis_tdata[36];
		decoded.tx_byte        = s_axis_tdata[44:37];
		decoded.rx_byte        = s_axis_tdata[52:45];
	end

	assign s_axis_tready = !valid_s1 || !q_status.full;
	assign push          = valid_s1 && !q_status.full;
	assign push_item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= decoded;
		end
	end

endmodule

### rtl/i2cms_queue.sv
`timescale 1ns / 1ps
module i2cms_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  i2cms_pkg::item_t     push_item,
	input  logic                 pop,
	output i2cms_pkg::item_t     head_item,
	output i2cms_pkg::q_status_t q_status
);

	i2cms_pkg::item_t               mem [i2cms_pkg::QUEUE_DEPTH];
	logic [i2cms_pkg::QPTR_BITS-1:0] wr_ptr_q;
	logic [i2cms_pkg::QPTR_BITS-1:0] rd_ptr_q;
	logic [i2cms_pkg::QCNT_BITS-1:0] count_q;

	assign q_status.full     = (count_q == i2cms_pkg::QCNT_BITS'(i2cms_pkg::QUEUE_DEPTH));
	assign q_status.nonempty = (count_q != '0);
	assign head_item         = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

endmodule

### rtl/i2cms_back.sv
`timescale 1ns / 1ps
module i2cms_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  i2cms_pkg::q_status_t                 q_status,
	input  i2cms_pkg::item_t                     head_item,
	output logic                                 pop,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [i2cms_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	i2cms_pkg::xfer_state_t st_q, st_d;
	i2cms_pkg::cnt_t        tx_rem_q, tx_rem_d;
	i2cms_pkg::cnt_t        rx_rem_q, rx_rem_d;
	i2cms_pkg::cnt_t        rx_total_q, rx_total_d;
	i2cms_pkg::cnt_t        rx_left;
	logic [6:0]             taddr_q, taddr_d;
	logic                   keep_q, keep_d;
	logic                   evt_on_q, evt_on_d;
	logic                   buf_on_q, buf_on_d;
	logic                   err_on_q, err_on_d;
	i2cms_pkg::result_t     res;
	i2cms_pkg::result_t     res_q;
	logic                   out_valid_q;
	i2cms_pkg::item_t       it;

	assign it  = head_item;
	assign pop = q_status.nonempty && (!out_valid_q || m_axis_tready);

	always_comb begin
		st_d       = st_q;
		tx_rem_d   = tx_rem_q;
		rx_rem_d   = rx_rem_q;
		rx_total_d = rx_total_q;
		taddr_d    = taddr_q;
		keep_d     = keep_q;
		evt_on_d   = evt_on_q;
		buf_on_d   = buf_on_q;
		err_on_d   = err_on_q;
		rx_left    = rx_rem_q;
		res        = '0;
		res.busy_before = i2cms_pkg::XS_READY;
		res.ack_control = i2cms_pkg::ACK_KEEP;

		unique case (it.op)
			i2cms_pkg::OP_START_TX, i2cms_pkg::OP_START_RX: begin
				res.busy_before = st_q;
				if (st_q != i2cms_pkg::XS_TX && st_q != i2cms_pkg::XS_RX) begin
					if (it.op == i2cms_pkg::OP_START_TX) begin
						tx_rem_d = it.length;
						st_d     = i2cms_pkg::XS_TX;
					end else begin
						rx_rem_d   = it.length;
						rx_total_d = it.length;
						st_d       = i2cms_pkg::XS_RX;
					end
					taddr_d           = it.target_addr;
					keep_d            = it.hold_bus;
					res.start_request = 1'b1;
					evt_on_d          = 1'b1;
					buf_on_d          = 1'b1;
					err_on_d          = 1'b1;
				end
			end
			i2cms_pkg::OP_EVENT: begin
				// Start bit: send the address byte with the direction bit.
				if (evt_on_q && it.ev.sb) begin
					if (st_q == i2cms_pkg::XS_TX) begin
						res.write_valid = 1'b1;
						res.write_byte  = {taddr_q, 1'b0};
					end else if (st_q == i2cms_pkg::XS_RX) begin
						res.write_valid = 1'b1;
						res.write_byte  = {taddr_q, 1'b1};
					end
				end
				if (evt_on_q && it.ev.addr) begin
					if (it.msl && st_q == i2cms_pkg::XS_RX
					    && rx_total_q == i2cms_pkg::cnt_t'(1)) begin
						res.ack_control = i2cms_pkg::ACK_CLEAR;
					end
					res.clear_addr = 1'b1;
				end
				// Byte transfer finished with the buffer drained and no bytes left closes a transmit.
				if (evt_on_q && it.ev.btf && it.ev.txe && st_q == i2cms_pkg::XS_TX
				    && tx_rem_q == '0) begin
					res.stop_request = !keep_q;
					st_d             = i2cms_pkg::XS_READY;
					evt_on_d         = 1'b0;
					buf_on_d         = 1'b0;
					tx_rem_d         = '0;
					res.notify_mask[i2cms_pkg::NT_TX_DONE] = 1'b1;
				end
				if (evt_on_q && it.ev.stopf) begin
					res.notify_mask[i2cms_pkg::NT_STOP] = 1'b1;
				end
				if (evt_on_q && buf_on_q && it.ev.txe) begin
					if (it.msl) begin
						if (st_q == i2cms_pkg::XS_TX && tx_rem_q != '0 && !res.write_valid) begin
							res.write_valid = 1'b1;
							res.write_byte  = it.tx_byte;
							res.tx_consumed = 1'b1;
							tx_rem_d        = tx_rem_q - i2cms_pkg::cnt_t'(1);
						end
					end else if (it.tra) begin
						res.notify_mask[i2cms_pkg::NT_DATA_RQ] = 1'b1;
					end
				end
				if (evt_on_q && buf_on_q && it.ev.rxne) begin
					if (it.msl) begin
						if (st_q == i2cms_pkg::XS_RX) begin
							if (rx_total_q != '0) begin
								if (rx_total_q > i2cms_pkg::cnt_t'(1)
								    && rx_rem_q == i2cms_pkg::cnt_t'(2)) begin
									res.ack_control = i2cms_pkg::ACK_CLEAR;
								end
								res.rx_valid = 1'b1;
								res.rx_data  = it.rx_byte;
								if (rx_rem_q != '0) begin
									rx_left = rx_rem_q - i2cms_pkg::cnt_t'(1);
								end
							end
							rx_rem_d = rx_left;
							if (rx_left == '0) begin
								res.stop_request = !keep_q;
								st_d             = i2cms_pkg::XS_READY;
								evt_on_d         = 1'b0;
								buf_on_d         = 1'b0;
								rx_rem_d         = '0;
								rx_total_d       = '0;
								res.ack_control  = i2cms_pkg::ACK_SET;
								res.notify_mask[i2cms_pkg::NT_RX_DONE] = 1'b1;
							end
						end
					end else if (!it.tra) begin
						res.notify_mask[i2cms_pkg::NT_DATA_RX] = 1'b1;
					end
				end
			end
			i2cms_pkg::OP_ERROR: begin
				if (err_on_q) begin
					res.notify_mask[i2cms_pkg::NT_ERR_HI:i2cms_pkg::NT_ERR_LO] = it.error_flags;
				end
			end
		endcase

		res.irq_enables = {err_on_d, buf_on_d, evt_on_d};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= i2cms_pkg::XS_READY;
			tx_rem_q    <= '0;
			rx_rem_q    <= '0;
			rx_total_q  <= '0;
			taddr_q     <= '0;
			keep_q      <= 1'b0;
			evt_on_q    <= 1'b0;
			buf_on_q    <= 1'b0;
			err_on_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				st_q        <= st_d;
				tx_rem_q    <= tx_rem_d;
				rx_rem_q    <= rx_rem_d;
				rx_total_q  <= rx_total_d;
				taddr_q     <= taddr_d;
				keep_q      <= keep_d;
				evt_on_q    <= evt_on_d;
				buf_on_q    <= buf_on_d;
				err_on_q    <= err_on_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(i2cms_pkg::OUT_TDATA_W - $bits(i2cms_pkg::result_t)){1'b0}}, res_q};

endmodule

### rtl/i2cms_checker.sv
`timescale 1ns / 1ps
module i2cms_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [i2cms_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	i2cms_pkg::result_t r;
	assign r = i2cms_pkg::result_t'(m_axis_tdata[$bits(i2cms_pkg::result_t)-1:0]);

	// A stalled result stays presented.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result withdrawn while stalled");

	// A granted START always leaves all three interrupt enables on.
	a_start_enables: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && r.start_request |-> r.irq_enables == 3'b111)
		else $error("start without interrupt enables");

	// A consumed transmit byte occupies the write slot and never coincides with START.
	a_tx_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && r.tx_consumed |-> r.write_valid && !r.start_request)
		else $error("transmit byte consumed without a write");

	// Idle write and receive slots carry zero data.
	a_zero_slots: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (r.write_valid || r.write_byte == 8'd0)
		&& (r.rx_valid || r.rx_data == 8'd0))
		else $error("data in an unused slot");

	// The ACK code is never the unused value and the busy code never three.
	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[24:23] != 2'd3 && m_axis_tdata[1:0] != 2'd3)
		else $error("undefined code in result");

endmodule

bind i2c_master_event_sequencer_top i2cms_checker u_i2cms_checker (.*);
